>>> sv/bresenham_line_stepper_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Bresenham line stepper
// Property wrappers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_STEPPER_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define BLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bresenham_line_stepper: assertion failed");
// next-cycle implication
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bresenham_line_stepper: assertion failed");
`else
`define BLS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and codes of the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // bit0 = steep (y is the major axis), bit1 = falling (y decreases)
    typedef struct packed
    {
        logic falling;
        logic steep;
    } line_case_t;

endpackage

>>> sv/bls_if.sv
// ----------------------------------------------------------------------------
// bls_if
// Valid/ready channels of the line stepper: command in, pixel out.
// ----------------------------------------------------------------------------
interface bls_cmd_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface bls_pixel_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

>>> sv/bls_step_core.sv
// ----------------------------------------------------------------------------
// bls_step_core
// Next-state logic of the stepper: line setup on start, one pixel on step.
// ----------------------------------------------------------------------------
module bls_step_core
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ERR_BITS   = 15
)
(
    input  logic                       operation,
    input  logic [COORD_BITS-1:0]      start_x,
    input  logic [COORD_BITS-1:0]      start_y,
    input  logic [COORD_BITS-1:0]      end_x,
    input  logic [COORD_BITS-1:0]      end_y,
    input  logic [COORD_BITS-1:0]      cur_x,
    input  logic [COORD_BITS-1:0]      cur_y,
    input  logic signed [ERR_BITS-1:0] error_term,
    input  logic [COORD_BITS-1:0]      steps_left,
    input  line_case_t                 line_case,
    input  logic [COORD_BITS-1:0]      delta_x,
    input  logic [COORD_BITS-1:0]      delta_y_abs,
    input  logic                       busy,
    output logic [COORD_BITS-1:0]      cur_x_next,
    output logic [COORD_BITS-1:0]      cur_y_next,
    output logic signed [ERR_BITS-1:0] error_term_next,
    output logic [COORD_BITS-1:0]      steps_left_next,
    output line_case_t                 line_case_next,
    output logic [COORD_BITS-1:0]      delta_x_next,
    output logic [COORD_BITS-1:0]      delta_y_abs_next,
    output logic                       busy_next,
    output logic                       emit
);

    localparam int PAD_BITS = ERR_BITS - COORD_BITS;

    // setup path
    logic                  swap;
    logic [COORD_BITS-1:0] x1, y1, x2, y2;
    logic [COORD_BITS-1:0] s_dx, s_dya, s_steps;
    logic                  s_falling, s_steep;

    // step path
    logic [COORD_BITS-1:0]      major, minor;
    logic signed [ERR_BITS-1:0] two_major, two_minor, err_add;
    logic [COORD_BITS-1:0]      x_major, y_major;
    logic                       minor_move;

    always_comb
    begin
        swap      = end_x < start_x;
        x1        = swap ? end_x : start_x;
        y1        = swap ? end_y : start_y;
        x2        = swap ? start_x : end_x;
        y2        = swap ? start_y : end_y;
        s_dx      = x2 - x1;
        s_falling = y2 < y1;
        s_dya     = s_falling ? (y1 - y2) : (y2 - y1);
        s_steep   = s_dx < s_dya;
        s_steps   = s_steep ? s_dya : s_dx;
    end

    always_comb
    begin
        major     = line_case.steep ? delta_y_abs : delta_x;
        minor     = line_case.steep ? delta_x : delta_y_abs;
        two_major = signed'({{(PAD_BITS - 1){1'b0}}, major, 1'b0});
        two_minor = signed'({{(PAD_BITS - 1){1'b0}}, minor, 1'b0});
        err_add   = error_term + two_minor;
        minor_move = !err_add[ERR_BITS-1];

        // major axis always advances by one
        x_major = line_case.steep ? cur_x : cur_x + COORD_BITS'(1);
        y_major = !line_case.steep ? cur_y
                : (line_case.falling ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1));
    end

    always_comb
    begin
        cur_x_next       = cur_x;
        cur_y_next       = cur_y;
        error_term_next  = error_term;
        steps_left_next  = steps_left;
        line_case_next   = line_case;
        delta_x_next     = delta_x;
        delta_y_abs_next = delta_y_abs;
        busy_next        = busy;
        emit             = 1'b0;

        if (operation == OP_START)
        begin
            cur_x_next           = x1;
            cur_y_next           = y1;
            delta_x_next         = s_dx;
            delta_y_abs_next     = s_dya;
            line_case_next.steep   = s_steep;
            line_case_next.falling = s_falling;
            steps_left_next      = s_steps;
            error_term_next      = -signed'({{PAD_BITS{1'b0}}, s_steps});
            busy_next            = s_steps != '0;
            emit                 = 1'b1;
        end
        else if (busy)
        begin
            cur_x_next      = x_major;
            cur_y_next      = y_major;
            error_term_next = err_add;
            if (minor_move)
            begin
                error_term_next = err_add - two_major;
                if (line_case.steep)
                    cur_x_next = x_major + COORD_BITS'(1);
                else if (line_case.falling)
                    cur_y_next = y_major - COORD_BITS'(1);
                else
                    cur_y_next = y_major + COORD_BITS'(1);
            end
            steps_left_next = steps_left - COORD_BITS'(1);
            busy_next       = steps_left_next != '0;
            emit            = 1'b1;
        end
    end

endmodule

>>> sv/bresenham_line_stepper.sv
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer Bresenham line rasterizer, at most one pixel per command transfer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd   : command channel. A start command (operation = OP_START) loads both
//           endpoints and returns the first pixel. Each step command
//           (operation = OP_STEP) returns the next pixel. A step while no line
//           is active is taken but returns nothing.
//   pixel : result channel with pixel_x, pixel_y and last_pixel, which marks
//           the final pixel of the line.
//   The pixel is registered: it appears on the clock after its command
//   transfer. Throughput is one command per cycle while the receiver takes
//   each pixel; line setup and the error-term add and compare all settle
//   between the command and the pixel output register.
//   The output register holds a pixel until it is taken; while the receiver
//   stalls with a pixel pending, cmd.ready is low. A new command is taken
//   in the same cycle the pending pixel leaves.
//   Reset clears the line state to idle and empties the output register.
//   A start while a line is active abandons that line.
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_macros.svh"

module bresenham_line_stepper
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    bls_cmd_if.sink     cmd,
    bls_pixel_if.source pixel
);

    // error term stays in [-2 * major, 0), reaching < 2 * major after the add
    localparam int ERR_BITS = COORD_BITS + 3;

    logic [COORD_BITS-1:0]      cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg, cur_y_next;
    logic signed [ERR_BITS-1:0] error_term_reg, error_term_next;
    logic [COORD_BITS-1:0]      steps_left_reg, steps_left_next;
    line_case_t                 line_case_reg, line_case_next;
    logic [COORD_BITS-1:0]      delta_x_reg, delta_x_next;
    logic [COORD_BITS-1:0]      delta_y_abs_reg, delta_y_abs_next;
    logic                       busy_reg, busy_next;
    logic                       emit;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_last_reg;

    logic cmd_fire;

    assign cmd.ready = !out_valid_reg || pixel.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    bls_step_core #(
        .COORD_BITS (COORD_BITS),
        .ERR_BITS   (ERR_BITS)
    ) u_core (
        .operation        (cmd.operation),
        .start_x          (cmd.start_x),
        .start_y          (cmd.start_y),
        .end_x            (cmd.end_x),
        .end_y            (cmd.end_y),
        .cur_x            (cur_x_reg),
        .cur_y            (cur_y_reg),
        .error_term       (error_term_reg),
        .steps_left       (steps_left_reg),
        .line_case        (line_case_reg),
        .delta_x          (delta_x_reg),
        .delta_y_abs      (delta_y_abs_reg),
        .busy             (busy_reg),
        .cur_x_next       (cur_x_next),
        .cur_y_next       (cur_y_next),
        .error_term_next  (error_term_next),
        .steps_left_next  (steps_left_next),
        .line_case_next   (line_case_next),
        .delta_x_next     (delta_x_next),
        .delta_y_abs_next (delta_y_abs_next),
        .busy_next        (busy_next),
        .emit             (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            error_term_reg  <= '0;
            steps_left_reg  <= '0;
            line_case_reg   <= '0;
            delta_x_reg     <= '0;
            delta_y_abs_reg <= '0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                cur_x_reg       <= cur_x_next;
                cur_y_reg       <= cur_y_next;
                error_term_reg  <= error_term_next;
                steps_left_reg  <= steps_left_next;
                line_case_reg   <= line_case_next;
                delta_x_reg     <= delta_x_next;
                delta_y_abs_reg <= delta_y_abs_next;
                busy_reg        <= busy_next;
            end
            if (cmd_fire && emit)
                out_valid_reg <= 1'b1;
            else if (pixel.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // pixel payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_fire && emit)
        begin
            out_x_reg    <= cur_x_next;
            out_y_reg    <= cur_y_next;
            out_last_reg <= !busy_next;
        end
    end

    assign pixel.valid      = out_valid_reg;
    assign pixel.pixel_x    = out_x_reg;
    assign pixel.pixel_y    = out_y_reg;
    assign pixel.last_pixel = out_last_reg;

    `BLS_ASSERT_IMPL(a_busy_matches_steps, clk, rst_n, 1'b1, busy_reg == (steps_left_reg != '0))
    `BLS_ASSERT_NEXT(a_start_emits, clk, rst_n, cmd_fire && cmd.operation == OP_START, pixel.valid)
    `BLS_ASSERT_IMPL(a_last_means_idle, clk, rst_n, pixel.valid && pixel.last_pixel, !busy_reg)
    `BLS_ASSERT_IMPL(a_error_negative, clk, rst_n, busy_reg, error_term_reg[ERR_BITS-1])

endmodule
